### hdl/tpo_pkg.sv
// shared constants and widths for the triangle pair overlap test
`timescale 1ns / 1ps
package tpo_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int NUM_VERTS      = 6;
  localparam int NUM_EDGE_AXES  = 11;
  localparam int NUM_COPL_AXES  = 6;
  localparam int NUM_AXES       = NUM_EDGE_AXES + NUM_COPL_AXES;
  localparam int OUT_TDATA_W    = 8;
  localparam int PIPE_DEPTH     = 8;
endpackage

### hdl/tpo_axis_gen.sv
// vertex relocation, edges, face normals and all seventeen candidate axes
`timescale 1ns / 1ps
module tpo_axis_gen import tpo_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int VW = COORD_BITS + 1,
  localparam int NW = 2 * COORD_BITS + 3,
  localparam int AW = 3 * COORD_BITS + 5,
  localparam int IN_W = ((18 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IN_W-1:0]      tdata,
  output logic signed [AW-1:0] axis [NUM_AXES][3],
  output logic signed [VW-1:0] vert [NUM_VERTS][3],
  output logic                 coplanar
);
  localparam int P1W = 2 * VW;
  localparam int P2W = NW + VW;
  localparam int S2W = P2W + 2;

  logic signed [COORD_BITS-1:0] raw [NUM_VERTS][3];
  logic signed [VW-1:0]  vr1 [NUM_VERTS][3], vr2 [NUM_VERTS][3], vr3 [NUM_VERTS][3];
  logic signed [VW-1:0]  vr4 [NUM_VERTS][3];
  logic signed [VW-1:0]  ed1 [NUM_VERTS][3], ed2 [NUM_VERTS][3], ed3 [NUM_VERTS][3];
  logic signed [P1W-1:0] pr1 [NUM_EDGE_AXES][3][2];
  logic signed [NW-1:0]  ax3 [NUM_EDGE_AXES][3], ax4 [NUM_EDGE_AXES][3];
  logic signed [P2W-1:0] pr2 [NUM_COPL_AXES][3][2];
  logic signed [P2W-1:0] cd4 [3][3];
  logic [2:0]            dz;

  for (genvar f = 0; f < NUM_VERTS; f++) begin : g_unpack
    for (genvar k = 0; k < 3; k++) begin : g_c
      assign raw[f][k] = tdata[(3 * f + k) * COORD_BITS +: COORD_BITS];
    end
  end

  // relative vertices and edges
  for (genvar f = 0; f < NUM_VERTS; f++) begin : g_s1
    localparam int NX = (f % 3 == 2) ? f - 2 : f + 1;
    for (genvar k = 0; k < 3; k++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          vr1[f][k] <= VW'(raw[f][k]) - VW'(raw[0][k]);
          ed1[f][k] <= VW'(raw[NX][k]) - VW'(raw[f][k]);
        end
      end
    end
  end

  // edge cross products: the face normals of both triangles, and every edge pair across them
  for (genvar g = 0; g < NUM_EDGE_AXES; g++) begin : g_s2
    localparam int XA = (g == 0) ? 0 : (g == 1) ? 3 : (g - 2) / 3;
    localparam int XB = (g == 0) ? 1 : (g == 1) ? 4 : 3 + (g - 2) % 3;
    for (genvar k = 0; k < 3; k++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          pr1[g][k][0] <= ed1[XA][(k + 1) % 3] * ed1[XB][(k + 2) % 3];
          pr1[g][k][1] <= ed1[XA][(k + 2) % 3] * ed1[XB][(k + 1) % 3];
          ax3[g][k]    <= NW'(pr1[g][k][0]) - NW'(pr1[g][k][1]);
          ax4[g][k]    <= ax3[g][k];
          axis[g][k]   <= AW'(ax4[g][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vr2 <= vr1;
      vr3 <= vr2;
      vr4 <= vr3;
      vert <= vr4;
      ed2 <= ed1;
      ed3 <= ed2;
    end
  end

  // in-plane edge normals
  for (genvar g = 0; g < NUM_COPL_AXES; g++) begin : g_s4
    localparam int NI = (g < 3) ? 0 : 1;
    localparam int EI = (g < 3) ? g : g;
    for (genvar k = 0; k < 3; k++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          pr2[g][k][0] <= ax3[NI][(k + 1) % 3] * ed3[EI][(k + 2) % 3];
          pr2[g][k][1] <= ax3[NI][(k + 2) % 3] * ed3[EI][(k + 1) % 3];
          axis[NUM_EDGE_AXES + g][k] <= AW'(pr2[g][k][0]) - AW'(pr2[g][k][1]);
        end
      end
    end
  end

  // second triangle against the first plane
  for (genvar i = 0; i < 3; i++) begin : g_cd
    for (genvar k = 0; k < 3; k++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          cd4[i][k] <= ax3[0][k] * vr3[3 + i][k];
        end
      end
    end
    assign dz[i] = (S2W'(cd4[i][0]) + S2W'(cd4[i][1]) + S2W'(cd4[i][2])) == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coplanar <= (ax4[0][0] != '0 || ax4[0][1] != '0 || ax4[0][2] != '0) &&
                  (ax4[1][0] != '0 || ax4[1][1] != '0 || ax4[1][2] != '0) && (&dz);
    end
  end
endmodule

### hdl/tpo_lane.sv
// one axis: projects both triangles and flags a strict gap
`timescale 1ns / 1ps
module tpo_lane import tpo_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int VW = COORD_BITS + 1,
  localparam int AW = 3 * COORD_BITS + 5
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] axis [3],
  input  logic signed [VW-1:0] vert [NUM_VERTS][3],
  output logic                 sep
);
  localparam int PW = VW + AW;
  localparam int DW = PW + 2;

  logic signed [PW-1:0] pr [NUM_VERTS][3];
  logic signed [DW-1:0] dt [NUM_VERTS];
  logic                 nz1, nz2;
  logic signed [DW-1:0] amin, amax, bmin, bmax;

  for (genvar f = 0; f < NUM_VERTS; f++) begin : g_v
    for (genvar k = 0; k < 3; k++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          pr[f][k] <= vert[f][k] * axis[k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dt[f] <= DW'(pr[f][0]) + DW'(pr[f][1]) + DW'(pr[f][2]);
      end
    end
  end

  always_comb begin
    amin = dt[0];
    amax = dt[0];
    bmin = dt[3];
    bmax = dt[3];
    for (int i = 1; i < 3; i++) begin
      if (dt[i] < amin) amin = dt[i];
      if (dt[i] > amax) amax = dt[i];
      if (dt[3 + i] < bmin) bmin = dt[3 + i];
      if (dt[3 + i] > bmax) bmax = dt[3 + i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz1 <= axis[0] != '0 || axis[1] != '0 || axis[2] != '0;
      nz2 <= nz1;
      sep <= nz2 && (amax < bmin || bmax < amin);
    end
  end
endmodule

### hdl/triangle_pair_overlap_test.sv
// triangle pair overlap test, top level with lanes and merge
//   channel | dir | tdata                                        | tuser
//   s_axis  | in  | tri_a_v0, tri_a_v1, tri_a_v2, tri_b_v0..v2    | -
//   m_axis  | out | overlap, coplanar_case                       | -
// one word per cycle in and out while the output is not stalled; results leave in order
// depth set by two multiply stages for the axes and one for the projections
// rst clears all valid bits; datapath registers are not reset
// a stalled output holds the whole pipeline, so s_tready is high when m_tready is or m_tvalid is low
`timescale 1ns / 1ps
module triangle_pair_overlap_test import tpo_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int VW = COORD_BITS + 1,
  localparam int AW = 3 * COORD_BITS + 5,
  localparam int IN_W = ((18 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,  // tri_a_v0, tri_a_v1, tri_a_v2, tri_b_v0, v1, v2
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // overlap, coplanar_case, zero fill
);
  logic                 en;
  logic [PIPE_DEPTH-1:0] vld;
  logic signed [AW-1:0] axis [NUM_AXES][3];
  logic signed [VW-1:0] vert [NUM_VERTS][3];
  logic                 cop5, cop6, cop7, cop8;
  logic [NUM_AXES-1:0]  sep;
  logic                 hit;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tpo_axis_gen #(.COORD_BITS(COORD_BITS)) u_gen (
    .clk(clk), .en(en), .tdata(s_tdata), .axis(axis), .vert(vert), .coplanar(cop5)
  );

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    tpo_lane #(.COORD_BITS(COORD_BITS)) u_lane (
      .clk(clk), .en(en), .axis(axis[g]), .vert(vert), .sep(sep[g])
    );
  end

  assign hit = cop8 ? !(|sep[NUM_AXES-1:NUM_EDGE_AXES]) : !(|sep[NUM_EDGE_AXES-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[PIPE_DEPTH-2:0], s_tvalid};
      m_tvalid <= vld[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cop6    <= cop5;
      cop7    <= cop6;
      cop8    <= cop7;
      m_tdata <= {{(OUT_TDATA_W - 2){1'b0}}, cop8, hit};
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word not in first stage");
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vld[PIPE_DEPTH-1]))
    else $error("result without matching pipeline entry");
endmodule
